FILE: rtl/pbbt_pkg.sv
// Shared types, constants and helper functions of the path bounding box tracker.
`timescale 1ns / 1ps
package pbbt_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int OUT_COUNT_BITS = 24;
   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = {OUT_COUNT_BITS{1'b1}};

   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 32;

   localparam logic [31:0] HALF_PIX    = 32'h0000_8000;
   localparam logic [31:0] FRAC_MASK   = 32'h0000_ffff;
   localparam logic [31:0] INT_MASK    = 32'hffff_0000;
   localparam logic [31:0] BOX_LO_INIT = 32'h7fff_ffff;
   localparam logic [31:0] BOX_HI_INIT = 32'h8000_0000;

   localparam logic [4:0]  FRAC_SHIFT_MAX   = 5'd16;
   localparam logic [4:0]  FRAC_SHIFT_RESET = 5'd16;
   localparam logic [14:0] CLIP_SIZE_RESET  = 15'd1;

   typedef enum logic [2:0] {
      OP_BEGIN = 3'd0,
      OP_MOVE  = 3'd1,
      OP_LINE  = 3'd2,
      OP_CLOSE = 3'd3,
      OP_END   = 3'd4,
      OP_QUERY = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      REG_FRAC_SHIFT  = 3'd0,
      REG_CLIP_LEFT   = 3'd1,
      REG_CLIP_TOP    = 3'd2,
      REG_CLIP_WIDTH  = 3'd3,
      REG_CLIP_HEIGHT = 3'd4,
      REG_STROKE_PAD  = 3'd5
   } reg_index_type;

   // Settings the query pipeline needs, all in 16.16 except the shift.
   typedef struct packed {
      logic [4:0]  frac_shift;
      logic [31:0] pad_half;
      logic [31:0] clip_x0;
      logic [31:0] clip_y0;
      logic [31:0] clip_x1;
      logic [31:0] clip_y1;
   } cfg_type;

   // One item as it leaves the path state stage.
   typedef struct packed {
      logic                      valid;
      logic                      cmd_ok;
      logic                      live;
      logic                      stroke;
      logic                      clip;
      logic                      accum;
      logic [OUT_COUNT_BITS-1:0] count;
      logic [31:0]               x0;
      logic [31:0]               y0;
      logic [31:0]               x1;
      logic [31:0]               y1;
      logic [31:0]               prior_x;
      logic [31:0]               prior_y;
      logic [31:0]               prior_w;
      logic [31:0]               prior_h;
   } qry_in_type;

   typedef struct packed {
      logic                      valid;
      logic                      cmd_ok;
      logic                      box_valid;
      logic [OUT_COUNT_BITS-1:0] point_count;
      logic signed [31:0]        box_x;
      logic signed [31:0]        box_y;
      logic signed [31:0]        box_w;
      logic signed [31:0]        box_h;
   } rsp_type;

   function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
      return ($signed(a) < $signed(b)) ? b : a;
   endfunction

endpackage

FILE: rtl/pbbt_if.sv
// Valid/ready channel interfaces for path commands and query results.
`timescale 1ns / 1ps
interface pbbt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic               want_stroke;
   logic               want_clip;
   logic               want_accum;
   logic signed [31:0] prior_x;
   logic signed [31:0] prior_y;
   logic signed [31:0] prior_w;
   logic signed [31:0] prior_h;

   modport source (output valid, op, pos_x, pos_y, want_stroke, want_clip, want_accum,
                   prior_x, prior_y, prior_w, prior_h, input ready);
   modport sink (input valid, op, pos_x, pos_y, want_stroke, want_clip, want_accum,
                 prior_x, prior_y, prior_w, prior_h, output ready);
endinterface

interface pbbt_rsp_if;
   logic               valid;
   logic               ready;
   logic               cmd_ok;
   logic [23:0]        point_count;
   logic               box_valid;
   logic signed [31:0] box_x;
   logic signed [31:0] box_y;
   logic signed [31:0] box_w;
   logic signed [31:0] box_h;

   modport source (output valid, cmd_ok, point_count, box_valid, box_x, box_y, box_w,
                   box_h, input ready);
   modport sink (input valid, cmd_ok, point_count, box_valid, box_x, box_y, box_w, box_h,
                 output ready);
endinterface

FILE: rtl/path_bounding_box_tracker.sv
// Top level of the path bounding box tracker: path state, registers and pipeline.
`timescale 1ns / 1ps
// The block takes one path command per item on the req_ channel (begin path, move,
// line, close figure, end figure, query) and returns exactly one result item per
// command on the rsp_ channel, in order. Coordinates are shifted into 16.16 by
// frac_shift. Only the running point count and min/max boxes are kept, never the path.
// A line with no current point comes back with cmd_ok low and changes nothing.
// A query returns the point count and the box, widened, optionally stroke padded,
// clipped and merged with a prior box, snapped to pixels and shifted back.
// Throughput is one item per cycle while the receiver keeps taking results. From
// acceptance to the valid result an item passes an input register, the path state
// stage that updates the running box, four query stages and the result register.
// Because all path state is updated in that one stage, back to back commands see
// each other's effects without any interlock. When the receiver stalls, the whole
// pipeline holds and req_chan.ready drops in the same cycle, so no item is lost or
// repeated. Reset empties the pipeline, restores the registers to their defaults
// and clears the path; a begin path command clears the path only. Registers must be
// written through the APB-style port only while idle; the block does not enforce it.
module path_bounding_box_tracker import pbbt_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   pbbt_req_if.sink             req_chan,
   pbbt_rsp_if.source           rsp_chan,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam int REPORT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   // Saturating count add with a carry in. A sum past the counter range sticks
   // at the maximum, which matches adding the carry and the operand one at a time.
   function automatic logic [COUNT_BITS-1:0] sat_sum(input logic [COUNT_BITS-1:0] a,
                                                     input logic [COUNT_BITS-1:0] b,
                                                     input logic                  cin);
      logic [COUNT_BITS+1:0] s;
      s = {2'b00, a} + {2'b00, b} + {{(COUNT_BITS+1){1'b0}}, cin};
      return (s > {2'b00, COUNT_MAX}) ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   //--------------------------------------------------------------------------
   // Configuration registers. The clip far edges and the stroke pad plus half
   // a pixel are kept precomputed so the query stages only compare.
   //--------------------------------------------------------------------------
   logic          cfg_write;
   reg_index_type cfg_index;

   logic [4:0]  frac_shift_ff, frac_shift_in;
   logic [15:0] clip_left_ff, clip_left_in;
   logic [15:0] clip_top_ff, clip_top_in;
   logic [14:0] clip_width_ff, clip_width_in;
   logic [14:0] clip_height_ff, clip_height_in;
   logic [30:0] stroke_pad_ff, stroke_pad_in;
   logic [31:0] pad_half_ff, pad_half_in;
   logic [31:0] clip_right_ff, clip_right_in;
   logic [31:0] clip_bottom_ff, clip_bottom_in;
   cfg_type     cfg;

   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign pready    = 1'b1;

   always_comb begin
      frac_shift_in  = frac_shift_ff;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      stroke_pad_in  = stroke_pad_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_FRAC_SHIFT: begin
               // Out of range shifts are dropped and the old value stays.
               if (pwdata[4:0] <= FRAC_SHIFT_MAX) begin
                  frac_shift_in = pwdata[4:0];
               end
            end
            REG_CLIP_LEFT:   clip_left_in   = pwdata[15:0];
            REG_CLIP_TOP:    clip_top_in    = pwdata[15:0];
            REG_CLIP_WIDTH:  clip_width_in  = pwdata[14:0];
            REG_CLIP_HEIGHT: clip_height_in = pwdata[14:0];
            REG_STROKE_PAD:  stroke_pad_in  = pwdata[30:0];
            default: ;
         endcase
      end
      pad_half_in    = {1'b0, stroke_pad_in} + HALF_PIX;
      clip_right_in  = {clip_left_in, 16'h0000} + {1'b0, clip_width_in, 16'h0000};
      clip_bottom_in = {clip_top_in, 16'h0000} + {1'b0, clip_height_in, 16'h0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_shift_ff  <= FRAC_SHIFT_RESET;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= CLIP_SIZE_RESET;
         clip_height_ff <= CLIP_SIZE_RESET;
         stroke_pad_ff  <= '0;
         pad_half_ff    <= HALF_PIX;
         clip_right_ff  <= {1'b0, CLIP_SIZE_RESET, 16'h0000};
         clip_bottom_ff <= {1'b0, CLIP_SIZE_RESET, 16'h0000};
      end else begin
         frac_shift_ff  <= frac_shift_in;
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         stroke_pad_ff  <= stroke_pad_in;
         pad_half_ff    <= pad_half_in;
         clip_right_ff  <= clip_right_in;
         clip_bottom_ff <= clip_bottom_in;
      end
   end

   always_comb begin
      case (cfg_index)
         REG_FRAC_SHIFT:  prdata = {27'b0, frac_shift_ff};
         REG_CLIP_LEFT:   prdata = {16'b0, clip_left_ff};
         REG_CLIP_TOP:    prdata = {16'b0, clip_top_ff};
         REG_CLIP_WIDTH:  prdata = {17'b0, clip_width_ff};
         REG_CLIP_HEIGHT: prdata = {17'b0, clip_height_ff};
         REG_STROKE_PAD:  prdata = {1'b0, stroke_pad_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.frac_shift = frac_shift_ff;
   assign cfg.pad_half   = pad_half_ff;
   assign cfg.clip_x0    = {clip_left_ff, 16'h0000};
   assign cfg.clip_y0    = {clip_top_ff, 16'h0000};
   assign cfg.clip_x1    = clip_right_ff;
   assign cfg.clip_y1    = clip_bottom_ff;

   //--------------------------------------------------------------------------
   // Pipeline control: every stage moves together whenever the result
   // register is empty or being taken.
   //--------------------------------------------------------------------------
   rsp_type rsp_q;
   logic    pipe_en;

   assign pipe_en        = !rsp_q.valid || rsp_chan.ready;
   assign req_chan.ready = pipe_en;

   //--------------------------------------------------------------------------
   // Input register. The point is shifted into 16.16 on the way in.
   //--------------------------------------------------------------------------
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic [31:0] px;
      logic [31:0] py;
      logic        stroke;
      logic        clip;
      logic        accum;
      logic [31:0] prior_x;
      logic [31:0] prior_y;
      logic [31:0] prior_w;
      logic [31:0] prior_h;
   } in_stage_type;

   in_stage_type s0_ff, s0_in;

   always_comb begin
      s0_in.valid   = req_chan.valid;
      s0_in.op      = op_type'(req_chan.op);
      s0_in.px      = req_chan.pos_x << frac_shift_ff;
      s0_in.py      = req_chan.pos_y << frac_shift_ff;
      s0_in.stroke  = req_chan.want_stroke;
      s0_in.clip    = req_chan.want_clip;
      s0_in.accum   = req_chan.want_accum;
      s0_in.prior_x = req_chan.prior_x;
      s0_in.prior_y = req_chan.prior_y;
      s0_in.prior_w = req_chan.prior_w;
      s0_in.prior_h = req_chan.prior_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         s0_ff <= s0_in;
      end
   end

   //--------------------------------------------------------------------------
   // Path state stage.
   //--------------------------------------------------------------------------
   logic [31:0]           done_min_x_ff, done_min_x_in, done_min_y_ff, done_min_y_in;
   logic [31:0]           done_max_x_ff, done_max_x_in, done_max_y_ff, done_max_y_in;
   logic [COUNT_BITS-1:0] done_count_ff, done_count_in;
   logic [31:0]           fig_min_x_ff, fig_min_x_in, fig_min_y_ff, fig_min_y_in;
   logic [31:0]           fig_max_x_ff, fig_max_x_in, fig_max_y_ff, fig_max_y_in;
   logic [63:0]           first_pt_ff, first_pt_in, last_kept_pt_ff, last_kept_pt_in;
   logic [COUNT_BITS-1:0] fig_kept_ff, fig_kept_in, fig_raw_ff, fig_raw_in;
   logic                  fig_open_ff, fig_open_in;

   logic                   fire;
   logic [63:0]            pt;
   logic                   fig_counts;
   logic                   close_adds;
   logic                   cmd_ok;
   logic [COUNT_BITS-1:0]  qcount;
   logic [REPORT_BITS-1:0] qcount_wide;
   qry_in_type             qry_ff, qry_in;

   assign fire = s0_ff.valid && pipe_en;
   assign pt   = {s0_ff.py, s0_ff.px};

   // A figure is folded into the finished part only with two or more kept
   // points; a close that ends away from the start adds the start once more.
   assign fig_counts = fig_open_ff && (fig_kept_ff > COUNT_BITS'(1));
   assign close_adds = (s0_ff.op == OP_CLOSE) && (last_kept_pt_ff != first_pt_ff);

   always_comb begin
      done_min_x_in   = done_min_x_ff;
      done_min_y_in   = done_min_y_ff;
      done_max_x_in   = done_max_x_ff;
      done_max_y_in   = done_max_y_ff;
      done_count_in   = done_count_ff;
      fig_min_x_in    = fig_min_x_ff;
      fig_min_y_in    = fig_min_y_ff;
      fig_max_x_in    = fig_max_x_ff;
      fig_max_y_in    = fig_max_y_ff;
      first_pt_in     = first_pt_ff;
      last_kept_pt_in = last_kept_pt_ff;
      fig_kept_in     = fig_kept_ff;
      fig_raw_in      = fig_raw_ff;
      fig_open_in     = fig_open_ff;
      cmd_ok          = 1'b1;

      // Move, close and end all finish the open figure first.
      if ((s0_ff.op == OP_MOVE) || (s0_ff.op == OP_CLOSE) || (s0_ff.op == OP_END)) begin
         if (fig_counts) begin
            done_count_in = sat_sum(done_count_ff, fig_kept_ff, close_adds);
            done_min_x_in = smin(done_min_x_ff, fig_min_x_ff);
            done_min_y_in = smin(done_min_y_ff, fig_min_y_ff);
            done_max_x_in = smax(done_max_x_ff, fig_max_x_ff);
            done_max_y_in = smax(done_max_y_ff, fig_max_y_ff);
         end
         fig_open_in = 1'b0;
      end

      case (s0_ff.op)
         OP_BEGIN: begin
            done_min_x_in   = BOX_LO_INIT;
            done_min_y_in   = BOX_LO_INIT;
            done_max_x_in   = BOX_HI_INIT;
            done_max_y_in   = BOX_HI_INIT;
            done_count_in   = '0;
            fig_min_x_in    = BOX_LO_INIT;
            fig_min_y_in    = BOX_LO_INIT;
            fig_max_x_in    = BOX_HI_INIT;
            fig_max_y_in    = BOX_HI_INIT;
            first_pt_in     = '0;
            last_kept_pt_in = '0;
            fig_kept_in     = '0;
            fig_raw_in      = '0;
            fig_open_in     = 1'b0;
         end
         OP_MOVE: begin
            fig_open_in     = 1'b1;
            first_pt_in     = pt;
            last_kept_pt_in = pt;
            fig_kept_in     = COUNT_BITS'(1);
            fig_raw_in      = COUNT_BITS'(1);
            fig_min_x_in    = s0_ff.px;
            fig_max_x_in    = s0_ff.px;
            fig_min_y_in    = s0_ff.py;
            fig_max_y_in    = s0_ff.py;
         end
         OP_LINE: begin
            if (!fig_open_ff) begin
               cmd_ok = 1'b0;
            end else begin
               fig_raw_in = sat_sum(fig_raw_ff, '0, 1'b1);
               // A repeat of the last kept point is counted raw but not kept.
               if (pt != last_kept_pt_ff) begin
                  last_kept_pt_in = pt;
                  fig_kept_in     = sat_sum(fig_kept_ff, '0, 1'b1);
                  fig_min_x_in    = smin(fig_min_x_ff, s0_ff.px);
                  fig_min_y_in    = smin(fig_min_y_ff, s0_ff.py);
                  fig_max_x_in    = smax(fig_max_x_ff, s0_ff.px);
                  fig_max_y_in    = smax(fig_max_y_ff, s0_ff.py);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_min_x_ff   <= BOX_LO_INIT;
         done_min_y_ff   <= BOX_LO_INIT;
         done_max_x_ff   <= BOX_HI_INIT;
         done_max_y_ff   <= BOX_HI_INIT;
         done_count_ff   <= '0;
         fig_min_x_ff    <= BOX_LO_INIT;
         fig_min_y_ff    <= BOX_LO_INIT;
         fig_max_x_ff    <= BOX_HI_INIT;
         fig_max_y_ff    <= BOX_HI_INIT;
         first_pt_ff     <= '0;
         last_kept_pt_ff <= '0;
         fig_kept_ff     <= '0;
         fig_raw_ff      <= '0;
         fig_open_ff     <= 1'b0;
      end else if (fire) begin
         done_min_x_ff   <= done_min_x_in;
         done_min_y_ff   <= done_min_y_in;
         done_max_x_ff   <= done_max_x_in;
         done_max_y_ff   <= done_max_y_in;
         done_count_ff   <= done_count_in;
         fig_min_x_ff    <= fig_min_x_in;
         fig_min_y_ff    <= fig_min_y_in;
         fig_max_x_ff    <= fig_max_x_in;
         fig_max_y_ff    <= fig_max_y_in;
         first_pt_ff     <= first_pt_in;
         last_kept_pt_ff <= last_kept_pt_in;
         fig_kept_ff     <= fig_kept_in;
         fig_raw_ff      <= fig_raw_in;
         fig_open_ff     <= fig_open_in;
      end
   end

   // Query snapshot: the open figure counts every raw point it has seen.
   always_comb begin
      qcount      = fig_open_ff ? sat_sum(done_count_ff, fig_raw_ff, 1'b0) : done_count_ff;
      qcount_wide = REPORT_BITS'(qcount);

      qry_in.valid   = s0_ff.valid;
      qry_in.cmd_ok  = cmd_ok;
      qry_in.live    = (s0_ff.op == OP_QUERY) && (qcount != '0);
      qry_in.stroke  = s0_ff.stroke;
      qry_in.clip    = s0_ff.clip;
      qry_in.accum   = s0_ff.accum;
      qry_in.count   = (qcount_wide > REPORT_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                                 : qcount_wide[OUT_COUNT_BITS-1:0];
      qry_in.x0      = fig_open_ff ? smin(done_min_x_ff, fig_min_x_ff) : done_min_x_ff;
      qry_in.y0      = fig_open_ff ? smin(done_min_y_ff, fig_min_y_ff) : done_min_y_ff;
      qry_in.x1      = fig_open_ff ? smax(done_max_x_ff, fig_max_x_ff) : done_max_x_ff;
      qry_in.y1      = fig_open_ff ? smax(done_max_y_ff, fig_max_y_ff) : done_max_y_ff;
      qry_in.prior_x = s0_ff.prior_x;
      qry_in.prior_y = s0_ff.prior_y;
      qry_in.prior_w = s0_ff.prior_w;
      qry_in.prior_h = s0_ff.prior_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qry_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         qry_ff <= qry_in;
      end
   end

   //--------------------------------------------------------------------------
   // Query pipeline and result register.
   //--------------------------------------------------------------------------
   pbbt_query u_query (
      .clock   (clock),
      .reset   (reset),
      .enable  (pipe_en),
      .q_in    (qry_ff),
      .cfg     (cfg),
      .rsp_out (rsp_q)
   );

   assign rsp_chan.valid       = rsp_q.valid;
   assign rsp_chan.cmd_ok      = rsp_q.cmd_ok;
   assign rsp_chan.point_count = rsp_q.point_count;
   assign rsp_chan.box_valid   = rsp_q.box_valid;
   assign rsp_chan.box_x       = rsp_q.box_x;
   assign rsp_chan.box_y       = rsp_q.box_y;
   assign rsp_chan.box_w       = rsp_q.box_w;
   assign rsp_chan.box_h       = rsp_q.box_h;

`ifndef SYNTHESIS
   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (s0_ff.op == OP_BEGIN) |=> !fig_open_ff && (done_count_ff == '0))
      else $error("begin path did not clear the path state");

   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      fig_open_ff |-> (fig_kept_ff != '0) && (fig_raw_ff >= fig_kept_ff))
      else $error("open figure has inconsistent point counts");

   a_done_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (done_count_ff != '0) |-> ($signed(done_min_x_ff) <= $signed(done_max_x_ff))
                               && ($signed(done_min_y_ff) <= $signed(done_max_y_ff)))
      else $error("finished box is inverted while it holds points");

   a_orphan_line: assert property (@(posedge clock) disable iff (reset)
      fire && (s0_ff.op == OP_LINE) && !fig_open_ff |=> qry_ff.valid && !qry_ff.cmd_ok)
      else $error("line without a current point was not flagged");
`endif

endmodule

FILE: rtl/pbbt_query.sv
// Query pipeline: widen, pad, clip, accumulate, snap and convert the box.
`timescale 1ns / 1ps
module pbbt_query import pbbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  qry_in_type q_in,
   input  cfg_type    cfg,
   output rsp_type    rsp_out
);

   typedef struct packed {
      logic                      valid;
      logic                      cmd_ok;
      logic                      live;
      logic                      clip;
      logic                      pok;
      logic [OUT_COUNT_BITS-1:0] count;
      logic [31:0]               x0;
      logic [31:0]               y0;
      logic [31:0]               x1;
      logic [31:0]               y1;
      logic [31:0]               ax0;
      logic [31:0]               ay0;
      logic [31:0]               ax1;
      logic [31:0]               ay1;
   } stage_type;

   stage_type a_ff, a_in;
   stage_type b_ff, b_in;
   stage_type c_ff, c_in;
   stage_type d_ff, d_in;
   rsp_type   out_ff, out_in;

   logic [31:0] offset;
   logic [31:0] dx, dy;
   logic        clipped_away;
   logic [31:0] box_w_raw, box_h_raw;

   // Widen by half a pixel (plus the stroke pad) and scale the prior box.
   // In this stage ax1/ay1 carry the scaled prior width and height.
   always_comb begin
      offset       = q_in.stroke ? cfg.pad_half : HALF_PIX;
      a_in.valid   = q_in.valid;
      a_in.cmd_ok  = q_in.cmd_ok;
      a_in.live    = q_in.live;
      a_in.clip    = q_in.clip;
      a_in.pok     = q_in.accum && ($signed(q_in.prior_w) > 32'sd0)
                     && ($signed(q_in.prior_h) > 32'sd0);
      a_in.count   = q_in.count;
      a_in.x0      = q_in.x0 - offset;
      a_in.y0      = q_in.y0 - offset;
      a_in.x1      = q_in.x1 + offset;
      a_in.y1      = q_in.y1 + offset;
      a_in.ax0     = q_in.prior_x << cfg.frac_shift;
      a_in.ay0     = q_in.prior_y << cfg.frac_shift;
      a_in.ax1     = q_in.prior_w << cfg.frac_shift;
      a_in.ay1     = q_in.prior_h << cfg.frac_shift;
   end

   // Clip against the device rectangle and form the far prior corner.
   always_comb begin
      b_in     = a_ff;
      b_in.ax1 = a_ff.ax0 + a_ff.ax1;
      b_in.ay1 = a_ff.ay0 + a_ff.ay1;
      if (a_ff.clip) begin
         b_in.x0 = smax(cfg.clip_x0, a_ff.x0);
         b_in.y0 = smax(cfg.clip_y0, a_ff.y0);
         b_in.x1 = smin(cfg.clip_x1, a_ff.x1);
         b_in.y1 = smin(cfg.clip_y1, a_ff.y1);
      end
   end

   // Drop a box that clipping emptied, then merge in the prior box.
   always_comb begin
      dx           = b_ff.x1 - b_ff.x0;
      dy           = b_ff.y1 - b_ff.y0;
      clipped_away = b_ff.clip && ((dx == '0) || dx[31] || (dy == '0) || dy[31]);
      c_in         = b_ff;
      c_in.live    = b_ff.live && !clipped_away;
      if (b_ff.pok) begin
         c_in.x0 = smin(b_ff.ax0, b_ff.x0);
         c_in.y0 = smin(b_ff.ay0, b_ff.y0);
         c_in.x1 = smax(b_ff.ax1, b_ff.x1);
         c_in.y1 = smax(b_ff.ay1, b_ff.y1);
      end
   end

   // Snap outward to whole pixels.
   always_comb begin
      d_in    = c_ff;
      d_in.x0 = c_ff.x0 & INT_MASK;
      d_in.y0 = c_ff.y0 & INT_MASK;
      d_in.x1 = (c_ff.x1 + FRAC_MASK) & INT_MASK;
      d_in.y1 = (c_ff.y1 + FRAC_MASK) & INT_MASK;
   end

   // Size and conversion back to user format; a dead query reports zeros.
   always_comb begin
      box_w_raw          = d_ff.x1 - d_ff.x0;
      box_h_raw          = d_ff.y1 - d_ff.y0;
      out_in.valid       = d_ff.valid;
      out_in.cmd_ok      = d_ff.cmd_ok;
      out_in.box_valid   = d_ff.live;
      out_in.point_count = '0;
      out_in.box_x       = '0;
      out_in.box_y       = '0;
      out_in.box_w       = '0;
      out_in.box_h       = '0;
      if (d_ff.live) begin
         out_in.point_count = d_ff.count;
         out_in.box_x       = $signed(d_ff.x0) >>> d_ff_shift(cfg.frac_shift);
         out_in.box_y       = $signed(d_ff.y0) >>> d_ff_shift(cfg.frac_shift);
         out_in.box_w       = $signed(box_w_raw) >>> d_ff_shift(cfg.frac_shift);
         out_in.box_h       = $signed(box_h_raw) >>> d_ff_shift(cfg.frac_shift);
      end
   end

   function automatic logic [4:0] d_ff_shift(input logic [4:0] sh);
      return sh;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         b_ff.valid   <= 1'b0;
         c_ff.valid   <= 1'b0;
         d_ff.valid   <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         d_ff   <= d_in;
         out_ff <= out_in;
      end
   end

   assign rsp_out = out_ff;

`ifndef SYNTHESIS
   a_box_has_points: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && out_ff.box_valid |-> out_ff.cmd_ok && (out_ff.point_count != '0))
      else $error("box reported without points");

   a_dead_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && !out_ff.box_valid |-> (out_ff.point_count == '0)
                                            && (out_ff.box_w == '0) && (out_ff.box_h == '0))
      else $error("result without a box carries nonzero fields");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !enable && out_ff.valid |=> out_ff.valid && $stable(out_ff.box_x)
                                  && $stable(out_ff.point_count))
      else $error("result changed while the pipeline was stalled");
`endif

endmodule
